// File: src/esc_pkg.sv
// Shared types and constants for the escape sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

    typedef enum logic [4:0] {
        M_NORMAL = 5'b00001,
        M_ESC    = 5'b00010,
        M_HEX    = 5'b00100,
        M_DEC    = 5'b01000,
        M_DROP   = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_end;
    } t_res;

    typedef struct packed {
        logic v0;
        logic v1;
        t_res r0;
        t_res r1;
    } t_push;

    localparam logic       REG_ESCAPE_CHAR  = 1'b0;
    localparam logic       REG_OUT_CAPACITY = 1'b1;

    localparam logic [7:0]  ESC_RESET = 8'd92;
    localparam logic [14:0] CAP_RESET = 15'd256;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'hFF;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;
    localparam logic [7:0] HEX_OFS  = 8'h37;

endpackage

`default_nettype wire

// File: src/escape_sequence_decoder_core.sv
// Top level of the escape sequence decoder: config registers, decoder and result queue.
//
// Source bytes enter on the input channel (i_in_valid, o_in_stall, i_in_byte),
// one byte per cycle while o_in_stall is low. Decoded bytes and the closing
// terminator leave on the output channel (o_out_valid, i_out_stall, o_out_byte,
// o_is_end); a terminator has o_is_end high and o_out_byte zero.
// Each result is registered in the queue and offered in order from its head.
// Throughput: one source byte per cycle; a byte may give two results, and
// the output drains one word per cycle through a four-word queue, so the
// input stalls only while the queue holds three or more words.
// When the receiver stalls, the queue holds its words and the input stalls
// once the queue cannot take two more.
// Configuration: index 0 sets the escape byte, index 1 the output capacity;
// o_cfg_ready stays high; the user must write only while the block is idle, unchecked.
// Reset (synchronous, active low) empties the queue, returns to plain text
// with zero counters and loads escape byte 92 and capacity 256.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_is_end,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [14:0] i_cfg_data
);

    logic [7:0]     r_escape_char;
    logic [14:0]    r_out_capacity;
    logic           fire;
    logic           full;
    esc_pkg::t_push push;
    esc_pkg::t_res  res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign fire        = i_in_valid && !full;
    assign o_out_byte  = res.out_byte;
    assign o_is_end    = res.is_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_char  <= esc_pkg::ESC_RESET;
            r_out_capacity <= esc_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                esc_pkg::REG_ESCAPE_CHAR:  r_escape_char  <= i_cfg_data[7:0];
                esc_pkg::REG_OUT_CAPACITY: r_out_capacity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    esc_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_byte         (i_in_byte),
        .i_escape_char  (r_escape_char),
        .i_out_capacity (r_out_capacity),
        .o_push         (push)
    );

    esc_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (res)
    );

endmodule

`default_nettype wire

// File: src/esc_decode.sv
// Decode state and per-word next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module esc_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_byte,
    input  wire logic [7:0]    i_escape_char,
    input  wire logic [14:0]   i_out_capacity,
    output esc_pkg::t_push     o_push
);

    esc_pkg::t_mode r_mode, n_mode;
    logic [9:0]     r_accum, n_accum;
    logic [1:0]     r_dc, n_dc;
    logic [14:0]    r_out_count, n_out_count;

    logic           nb_do, nb_v, nb_stop;
    logic [14:0]    nb_cnt, limit;
    esc_pkg::t_res  nb_res, pre_res;
    logic           pre_v;
    logic [7:0]     hex_u;
    logic           is_dig, hex_let, hex_dig;
    logic [9:0]     hex_acc, dec_acc;
    logic [1:0]     inc_dc;

    always_comb begin
        is_dig  = (i_byte >= esc_pkg::CH_0) && (i_byte <= esc_pkg::CH_9);
        hex_u   = ((i_byte >= esc_pkg::CH_LO_A) && (i_byte <= esc_pkg::CH_LO_Z)) ?
                  (i_byte - esc_pkg::CASE_OFS) : i_byte;
        hex_let = (hex_u >= esc_pkg::CH_UP_A) && (hex_u <= esc_pkg::CH_UP_Z);
        hex_dig = (hex_u >= esc_pkg::CH_0) && (hex_u <= esc_pkg::CH_9);
        hex_acc = r_accum;
        if (hex_let) begin
            hex_acc = {r_accum[5:0], 4'b0000} + {2'b00, hex_u - esc_pkg::HEX_OFS};
        end else if (hex_dig) begin
            hex_acc = {r_accum[5:0], 4'b0000} + {6'd0, hex_u[3:0]};
        end
        dec_acc = {r_accum[6:0], 3'b000} + {r_accum[8:0], 1'b0} + {6'd0, i_byte[3:0]};
        inc_dc  = r_dc + 2'd1;
        limit   = (i_out_capacity == 15'd0) ? 15'd0 : (i_out_capacity - 15'd1);
    end

    always_comb begin
        n_mode      = r_mode;
        n_accum     = r_accum;
        n_dc        = r_dc;
        n_out_count = r_out_count;
        nb_do       = 1'b0;
        nb_cnt      = r_out_count;
        pre_v       = 1'b0;
        pre_res     = '{out_byte: i_byte, is_end: 1'b0};
        nb_v        = 1'b0;
        nb_res      = '{out_byte: i_byte, is_end: 1'b0};
        nb_stop     = 1'b0;

        case (r_mode)
            esc_pkg::M_NORMAL: begin
                nb_do = 1'b1;
            end
            esc_pkg::M_ESC: begin
                n_mode = esc_pkg::M_NORMAL;
                if (i_byte == esc_pkg::CH_NUL) begin
                    nb_do = 1'b1;
                end else if (i_byte == esc_pkg::CH_LO_X || i_byte == esc_pkg::CH_UP_X) begin
                    n_mode  = esc_pkg::M_HEX;
                    n_accum = 10'd0;
                    n_dc    = 2'd0;
                end else if (is_dig) begin
                    n_mode  = esc_pkg::M_DEC;
                    n_accum = {6'd0, i_byte[3:0]};
                    n_dc    = 2'd1;
                end else begin
                    pre_v       = 1'b1;
                    n_out_count = r_out_count + 15'd1;
                    if (i_byte == esc_pkg::CH_LO_T) begin
                        pre_res.out_byte = esc_pkg::CH_TAB;
                    end else if (i_byte == esc_pkg::CH_LO_N) begin
                        pre_res.out_byte = esc_pkg::CH_LF;
                    end else if (i_byte == esc_pkg::CH_UP_F) begin
                        pre_res.out_byte = esc_pkg::CH_FF;
                    end
                end
            end
            esc_pkg::M_HEX: begin
                if (i_byte == esc_pkg::CH_NUL) begin
                    n_mode           = esc_pkg::M_NORMAL;
                    pre_v            = 1'b1;
                    pre_res.out_byte = r_accum[7:0];
                    nb_do            = 1'b1;
                    nb_cnt           = r_out_count + 15'd1;
                end else begin
                    n_accum = hex_acc;
                    n_dc    = inc_dc;
                    if (inc_dc >= 2'd2) begin
                        n_mode           = esc_pkg::M_NORMAL;
                        pre_v            = 1'b1;
                        pre_res.out_byte = hex_acc[7:0];
                        n_out_count      = r_out_count + 15'd1;
                        n_accum          = 10'd0;
                        n_dc             = 2'd0;
                    end
                end
            end
            esc_pkg::M_DEC: begin
                if (is_dig) begin
                    n_accum = dec_acc;
                    n_dc    = inc_dc;
                    if (inc_dc == 2'd3) begin
                        n_mode           = esc_pkg::M_NORMAL;
                        pre_v            = 1'b1;
                        pre_res.out_byte = dec_acc[7:0];
                        n_out_count      = r_out_count + 15'd1;
                        n_accum          = 10'd0;
                        n_dc             = 2'd0;
                    end
                end else begin
                    n_mode           = esc_pkg::M_NORMAL;
                    pre_v            = 1'b1;
                    pre_res.out_byte = r_accum[7:0];
                    n_accum          = 10'd0;
                    n_dc             = 2'd0;
                    nb_do            = 1'b1;
                    nb_cnt           = r_out_count + 15'd1;
                    n_out_count      = nb_cnt;
                end
            end
            esc_pkg::M_DROP: begin
                if (i_byte == esc_pkg::CH_NUL) begin
                    n_mode      = esc_pkg::M_NORMAL;
                    n_out_count = 15'd0;
                end
            end
            default: begin
                n_mode = esc_pkg::M_NORMAL;
                nb_do  = 1'b1;
            end
        endcase

        if (nb_do) begin
            n_mode  = esc_pkg::M_NORMAL;
            nb_stop = (i_byte == esc_pkg::CH_NUL) || (i_byte == esc_pkg::CH_QUOTE) ||
                      (nb_cnt >= limit);
            if (nb_stop) begin
                nb_v        = 1'b1;
                nb_res      = '{out_byte: 8'd0, is_end: 1'b1};
                n_out_count = 15'd0;
                n_accum     = 10'd0;
                n_dc        = 2'd0;
                n_mode      = (i_byte == esc_pkg::CH_NUL) ? esc_pkg::M_NORMAL
                                                          : esc_pkg::M_DROP;
            end else if (i_byte == i_escape_char) begin
                n_mode      = esc_pkg::M_ESC;
                n_out_count = nb_cnt;
            end else begin
                nb_v        = 1'b1;
                n_out_count = nb_cnt + 15'd1;
            end
        end
    end

    always_comb begin
        o_push.v0 = i_fire && (pre_v || nb_v);
        o_push.v1 = i_fire && pre_v && nb_v;
        o_push.r0 = pre_v ? pre_res : nb_res;
        o_push.r1 = nb_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= esc_pkg::M_NORMAL;
            r_accum     <= 10'd0;
            r_dc        <= 2'd0;
            r_out_count <= 15'd0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_accum     <= n_accum;
            r_dc        <= n_dc;
            r_out_count <= n_out_count;
        end
    end

endmodule

`default_nettype wire

// File: src/esc_out_queue.sv
// Four-word result queue taking up to two words per cycle.
`timescale 1ns / 1ps
`default_nettype none

module esc_out_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire esc_pkg::t_push i_push,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_stall,
    output esc_pkg::t_res      o_res
);

    esc_pkg::t_res r_mem [4];
    logic [1:0]    r_wr, r_rd;
    logic [2:0]    r_cnt, n_cnt;
    logic          pop;
    logic [1:0]    wr_next;

    always_comb begin
        o_valid = (r_cnt != 3'd0);
        o_full  = (r_cnt >= 3'd3);
        o_res   = r_mem[r_rd];
        pop     = o_valid && !i_stall;
        wr_next = r_wr + 2'd1;
        n_cnt   = r_cnt + {2'b00, i_push.v0} + {2'b00, i_push.v1} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr_next] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= r_wr + {1'b0, i_push.v0} + {1'b0, i_push.v1};
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: verif/escape_sequence_decoder_core_tb.sv
// Self-checking testbench for escape_sequence_decoder_core with its own decoder predictor.
`timescale 1ns / 1ps

module testbench;

    localparam logic [8*30-1:0] OPENING = {
        esc_pkg::ESC_RESET, "t", esc_pkg::ESC_RESET, "n", esc_pkg::ESC_RESET, "F",
        esc_pkg::ESC_RESET, esc_pkg::CH_QUOTE,
        esc_pkg::ESC_RESET, "x41", esc_pkg::ESC_RESET, "Xg$", esc_pkg::ESC_RESET, "255",
        esc_pkg::ESC_RESET, "9a",
        esc_pkg::CH_FF, esc_pkg::ESC_RESET, "7", esc_pkg::CH_NUL, esc_pkg::CH_QUOTE, "q",
        esc_pkg::CH_NUL
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = esc_pkg::REG_ESCAPE_CHAR;
    logic [14:0] i_cfg_data = 15'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_is_end;
    logic        o_cfg_ready;

    esc_pkg::t_mode mode_r = esc_pkg::M_NORMAL;
    logic [9:0]  acc_r = 10'd0;
    logic [1:0]  cnt_r = 2'd0;
    logic [14:0] out_cnt = 15'd0;
    logic [7:0]  esc_r = esc_pkg::ESC_RESET;
    logic [14:0] cap_r = esc_pkg::CAP_RESET;

    esc_pkg::t_res decoded_q[$];
    logic [7:0]  src_q[$];
    int          n_err = 0;
    int          n_queued = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    escape_sequence_decoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_is_end    (o_is_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void emit_word(logic [7:0] b, logic e);
        esc_pkg::t_res w;
        w.out_byte = b;
        w.is_end = e;
        decoded_q.push_back(w);
    endfunction

    function automatic void emit_data(logic [7:0] b);
        emit_word(b, 1'b0);
        out_cnt = out_cnt + 15'd1;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= esc_pkg::CH_0 && b <= esc_pkg::CH_9;
    endfunction

    function automatic void plain_byte(logic [7:0] b);
        logic [14:0] lim;
        lim = (cap_r == 15'd0) ? 15'd0 : cap_r - 15'd1;
        if (b == esc_pkg::CH_NUL || b == esc_pkg::CH_QUOTE || out_cnt >= lim) begin
            emit_word(esc_pkg::CH_NUL, 1'b1);
            out_cnt = 15'd0;
            acc_r = 10'd0;
            cnt_r = 2'd0;
            mode_r = (b == esc_pkg::CH_NUL) ? esc_pkg::M_NORMAL : esc_pkg::M_DROP;
        end else if (b == esc_r) begin
            mode_r = esc_pkg::M_ESC;
        end else begin
            emit_data(b);
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        logic [7:0] u;
        case (mode_r)
            esc_pkg::M_ESC: begin
                mode_r = esc_pkg::M_NORMAL;
                if (b == esc_pkg::CH_NUL) begin
                    plain_byte(b);
                end else if (b == esc_pkg::CH_LO_T) begin
                    emit_data(esc_pkg::CH_TAB);
                end else if (b == esc_pkg::CH_LO_N) begin
                    emit_data(esc_pkg::CH_LF);
                end else if (b == esc_pkg::CH_UP_F) begin
                    emit_data(esc_pkg::CH_FF);
                end else if (b == esc_pkg::CH_LO_X || b == esc_pkg::CH_UP_X) begin
                    mode_r = esc_pkg::M_HEX;
                    acc_r = 10'd0;
                    cnt_r = 2'd0;
                end else if (is_digit(b)) begin
                    mode_r = esc_pkg::M_DEC;
                    acc_r = {2'b00, b - esc_pkg::CH_0};
                    cnt_r = 2'd1;
                end else begin
                    emit_data(b);
                end
            end
            esc_pkg::M_HEX: begin
                if (b == esc_pkg::CH_NUL) begin
                    mode_r = esc_pkg::M_NORMAL;
                    emit_data(acc_r[7:0]);
                    plain_byte(b);
                end else begin
                    u = (b >= esc_pkg::CH_LO_A && b <= esc_pkg::CH_LO_Z) ?
                        b - esc_pkg::CASE_OFS : b;
                    if (u >= esc_pkg::CH_UP_A && u <= esc_pkg::CH_UP_Z) begin
                        acc_r = acc_r * 10'd16 + {2'b00, u - esc_pkg::HEX_OFS};
                    end else if (is_digit(u)) begin
                        acc_r = acc_r * 10'd16 + {2'b00, u - esc_pkg::CH_0};
                    end
                    cnt_r = cnt_r + 2'd1;
                    if (cnt_r >= 2'd2) begin
                        mode_r = esc_pkg::M_NORMAL;
                        emit_data(acc_r[7:0]);
                        acc_r = 10'd0;
                        cnt_r = 2'd0;
                    end
                end
            end
            esc_pkg::M_DEC: begin
                if (is_digit(b)) begin
                    acc_r = acc_r * 10'd10 + {2'b00, b - esc_pkg::CH_0};
                    cnt_r = cnt_r + 2'd1;
                    if (cnt_r == 2'd3) begin
                        mode_r = esc_pkg::M_NORMAL;
                        emit_data(acc_r[7:0]);
                        acc_r = 10'd0;
                        cnt_r = 2'd0;
                    end
                end else begin
                    mode_r = esc_pkg::M_NORMAL;
                    emit_data(acc_r[7:0]);
                    acc_r = 10'd0;
                    cnt_r = 2'd0;
                    plain_byte(b);
                end
            end
            esc_pkg::M_DROP: begin
                if (b == esc_pkg::CH_NUL) begin
                    mode_r = esc_pkg::M_NORMAL;
                    out_cnt = 15'd0;
                end
            end
            default: begin
                mode_r = esc_pkg::M_NORMAL;
                plain_byte(b);
            end
        endcase
    endfunction

    // source byte driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_in_byte);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (src_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    i_in_byte <= src_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // decoded word monitor
    always @(posedge i_clk) begin
        esc_pkg::t_res want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: expected no word actual byte %h end %b",
                             $time, o_out_byte, o_is_end);
                    n_err++;
                end else begin
                    want = decoded_q.pop_front();
                    if (want.out_byte !== o_out_byte) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.out_byte, o_out_byte);
                        n_err++;
                    end
                    if (want.is_end !== o_is_end) begin
                        $display("%0t: is_end expected %b actual %b",
                                 $time, want.is_end, o_is_end);
                        n_err++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic push_item(logic [7:0] b);
        src_q.push_back(b);
        n_queued++;
    endtask

    task automatic settle();
        do @(negedge i_clk); while (src_q.size() != 0 || i_in_valid || decoded_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [14:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == esc_pkg::REG_ESCAPE_CHAR) begin
            esc_r = val[7:0];
        end else begin
            cap_r = val;
        end
    endtask

    task automatic add_string(bit close);
        int n_tok;
        int t;
        int j;
        logic [7:0] c;
        n_tok = $urandom_range(14);
        for (t = 0; t < n_tok; t++) begin
            case ($urandom_range(11))
                0: begin
                    push_item(esc_r);
                    case ($urandom_range(3))
                        0: c = esc_pkg::CH_LO_T;
                        1: c = esc_pkg::CH_LO_N;
                        2: c = esc_pkg::CH_UP_F;
                        default: c = esc_pkg::CH_QUOTE;
                    endcase
                    push_item(c);
                end
                1: begin
                    push_item(esc_r);
                    push_item($urandom_range(1) ? esc_pkg::CH_LO_X : esc_pkg::CH_UP_X);
                    for (j = 0; j < 2; j++) begin
                        case ($urandom_range(15))
                            0: c = esc_pkg::CH_NUL;
                            1, 2, 3: c = 8'($urandom_range(1, 255));
                            4, 5, 6, 7: c = 8'(esc_pkg::CH_0 + $urandom_range(9));
                            8, 9, 10, 11: c = 8'(esc_pkg::CH_UP_A + $urandom_range(25));
                            default: c = 8'(esc_pkg::CH_LO_A + $urandom_range(25));
                        endcase
                        push_item(c);
                    end
                end
                2: begin
                    push_item(esc_r);
                    repeat ($urandom_range(1, 3)) begin
                        push_item(8'(esc_pkg::CH_0 + $urandom_range(9)));
                    end
                end
                3: begin
                    push_item(esc_r);
                    push_item(8'($urandom_range(255)));
                end
                4: begin
                    push_item(8'($urandom_range(255)));
                end
                default: begin
                    c = 8'($urandom_range(1, 255));
                    if (c == esc_pkg::CH_QUOTE || c == esc_r) begin
                        c = "a";
                    end
                    push_item(c);
                end
            endcase
        end
        if (close) begin
            case ($urandom_range(9))
                7, 8: begin
                    push_item(esc_pkg::CH_QUOTE);
                    repeat ($urandom_range(3)) push_item(8'($urandom_range(1, 255)));
                    push_item(esc_pkg::CH_NUL);
                end
                9: ;
                default: push_item(esc_pkg::CH_NUL);
            endcase
        end
    endtask

    initial begin
        int ph;
        int k;
        logic [7:0] esc_v;
        logic [14:0] cap_v;
        logic [14:0] wd;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (ph = 0; ph < 10; ph++) begin
            gap_pct = (ph < 3) ? 7 : (ph < 6) ? 50 : 0;
            stall_pct = (ph < 3) ? 50 : (ph < 6) ? 7 : 0;
            n_queued = 0;
            if (ph == 0) begin
                for (k = 29; k >= 0; k--) push_item(OPENING[k*8 +: 8]);
            end else begin
                case (ph)
                    1: begin esc_v = esc_pkg::ESC_RESET; cap_v = 15'd1; end
                    2: begin esc_v = esc_pkg::CH_QUOTE; cap_v = 15'd6; end
                    3: begin esc_v = esc_pkg::CH_NUL; cap_v = 15'd0; end
                    4: begin esc_v = 8'hFF; cap_v = 15'h7FFF; end
                    5: begin esc_v = 8'($urandom); cap_v = 15'($urandom_range(2, 20)); end
                    6: begin esc_v = esc_pkg::ESC_RESET; cap_v = 15'd3; end
                    7: begin esc_v = 8'($urandom); cap_v = 15'd300; end
                    8: begin esc_v = esc_pkg::ESC_RESET; cap_v = 15'd12; end
                    default: begin
                        esc_v = 8'($urandom);
                        cap_v = 15'($urandom_range(1, 40));
                    end
                endcase
                wd = 15'($urandom);
                wd[7:0] = esc_v;
                write_reg(esc_pkg::REG_ESCAPE_CHAR, wd);
                write_reg(esc_pkg::REG_OUT_CAPACITY, cap_v);
            end
            while (n_queued < 80) add_string(1'b1);
            settle();
            while (n_queued < 158) add_string(1'b1);
            add_string(1'b0);
            settle();
        end
        if (n_err == 0) begin
            $display("PASS escape_sequence_decoder_core");
        end else begin
            $display("FAIL escape_sequence_decoder_core");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL escape_sequence_decoder_core");
        $finish;
    end

endmodule
